// ===== design/ccas_pkg.sv =====
// ---------------------------------------------------------------------------
// ccas_pkg
// Shared constants and the key qualification function for the clock, calendar and alarm setter.
// ---------------------------------------------------------------------------
package ccas_pkg;

    // Scan ticks per second; also the tick divider reload value
    localparam logic [7:0] SCANS_PER_SECOND = 8'd20;

    // Configuration register indexes
    localparam logic CFG_REPEAT_START = 1'b0;
    localparam logic CFG_LONG_PRESS   = 1'b1;

    // Configuration reset values
    localparam logic [7:0] REPEAT_START_RST = 8'd20;
    localparam logic [7:0] LONG_PRESS_RST   = 8'd60;

    // Reset time of day and alarm
    localparam logic [4:0] HOUR_RST       = 5'd9;
    localparam logic [4:0] ALARM_HOUR_RST = 5'd9;

    // Divider value below which the edited field blanks
    localparam logic [7:0] BLINK_LIMIT = 8'd10;

    // Alarm rings while the clock second is at most this
    localparam logic [5:0] RING_LAST_SECOND = 6'd10;

    // Key qualification: first scan, or odd hold counts at/after the threshold
    function automatic logic key_acts(input logic [7:0] hold, input logic [7:0] thr);
        key_acts = (hold == 8'd1) || ((hold >= thr) && hold[0]);
    endfunction

endpackage

// ===== design/clock_calendar_alarm_setter_unit.sv =====
// ---------------------------------------------------------------------------
// clock_calendar_alarm_setter_unit
// Key-driven real time clock and calendar with a settable alarm.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-----------------------------------
//  s_      | in        | s_valid / s_ready   | mode and adjust key hold counts
//  m_      | out       | m_valid / m_ready   | shown time, date, alarm and mode
//  cfg_    | in        | cfg_valid/cfg_ready | register index, 8-bit write data
//
//  One beat in gives one beat out. A beat waits in the input register;
//  when it advances, the clock state is updated and the result register
//  loaded in the same cycle. Throughput is one beat per cycle unless the
//  result stalls, set by the single edit/carry pass between the registers.
//  Synchronous active-low reset puts the clock at 09:00:00 on Sunday 1 Jan 00,
//  alarm at 09:00:00 and off. A stalled result register holds the input
//  register, which in turn holds s_ready low. cfg_ready is always high.
//
module clock_calendar_alarm_setter_unit (
    input  logic       aclk,
    input  logic       aresetn,
    // scan tick beats
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_mode_hold,
    input  logic [7:0] s_adjust_hold,
    // result beats
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_shown_hour,
    output logic [5:0] m_shown_minute,
    output logic [5:0] m_shown_second,
    output logic [4:0] m_day_of_month,
    output logic [3:0] m_month_number,
    output logic [6:0] m_year_in_century,
    output logic [2:0] m_weekday,
    output logic       m_alarm_enabled,
    output logic       m_alarm_ringing,
    output logic [3:0] m_edit_mode,
    output logic       m_blink_phase,
    output logic       m_alarm_page,
    // configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_WEEKDAY,
        MODE_HOUR,
        MODE_MINUTE,
        MODE_SECOND,
        MODE_ALARM_ON,
        MODE_ALARM_HOUR,
        MODE_ALARM_MINUTE,
        MODE_ALARM_SECOND,
        MODE_DAY,
        MODE_MONTH,
        MODE_YEAR
    } mode_t;

    // Configuration
    logic [7:0] repeat_start_reg, long_press_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_mode_reg, in_adjust_reg;

    // Clock state
    mode_t      mode_reg, mode_next;
    logic [7:0] div_reg, div_next;
    logic [5:0] sec_reg, sec_next;
    logic [5:0] min_reg, min_next;
    logic [4:0] hour_reg, hour_next;
    logic [4:0] day_reg, day_next;
    logic [3:0] month_reg, month_next;
    logic [6:0] year_reg, year_next;
    logic [2:0] wday_reg, wday_next;
    logic [4:0] ahour_reg, ahour_next;
    logic [5:0] amin_reg, amin_next;
    logic [5:0] asec_reg, asec_next;
    logic       aon_reg, aon_next;
    logic       page_reg, page_next;

    // Result register
    logic       m_valid_reg;
    logic [4:0] m_hour_reg;
    logic [5:0] m_min_reg, m_sec_reg;
    logic [4:0] m_day_reg;
    logic [3:0] m_month_reg;
    logic [6:0] m_year_reg;
    logic [2:0] m_wday_reg;
    logic       m_aon_reg, m_ring_reg, m_blink_reg, m_page_reg;
    logic [3:0] m_mode_reg;

    // Edited values (before the one-second carry)
    logic [5:0] e_sec, e_min;
    logic [4:0] e_hour, e_day;
    logic [3:0] e_month;
    logic [6:0] e_year;
    logic       mode_up, mode_long, adj, leap, feb_over, short_over;
    logic       advance, sec_tick;
    logic [7:0] div_dec;
    logic       ring_next, blink_next;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign mode_up   = ccas_pkg::key_acts(in_mode_reg, repeat_start_reg);
    assign mode_long = ccas_pkg::key_acts(in_mode_reg, long_press_reg);
    assign adj       = ccas_pkg::key_acts(in_adjust_reg, repeat_start_reg);

    assign leap       = (year_reg[1:0] == 2'd0);
    assign feb_over   = (month_reg == 4'd2) && (day_reg >= (leap ? 5'd30 : 5'd29));
    assign short_over = (day_reg >= 5'd31) && ((month_reg == 4'd4) || (month_reg == 4'd6)
                        || (month_reg == 4'd9) || (month_reg == 4'd11));

    // Edit step: short-month rollover when idle, and key actions on the mode in force at the start of the tick
    always_comb begin
        mode_next  = mode_reg;
        e_sec      = sec_reg;
        e_min      = min_reg;
        e_hour     = hour_reg;
        e_day      = day_reg;
        e_month    = month_reg;
        e_year     = year_reg;
        wday_next  = wday_reg;
        ahour_next = ahour_reg;
        amin_next  = amin_reg;
        asec_next  = asec_reg;
        aon_next   = aon_reg;
        page_next  = page_reg;
        case (mode_reg)
            MODE_IDLE: begin
                // short months roll over here, before any key
                if (feb_over) begin
                    e_day   = 5'd1;
                    e_month = 4'd3;
                end else if (short_over) begin
                    e_day   = 5'd1;
                    e_month = month_reg + 4'd1;
                end
                if (mode_up) mode_next = MODE_WEEKDAY;
            end
            MODE_WEEKDAY: begin
                if (mode_up) mode_next = MODE_HOUR;
                if (adj) wday_next = (wday_reg >= 3'd6) ? 3'd0 : wday_reg + 3'd1;
            end
            MODE_HOUR: begin
                if (mode_up) mode_next = MODE_MINUTE;
                if (adj) e_hour = (hour_reg >= 5'd23) ? 5'd0 : hour_reg + 5'd1;
            end
            MODE_MINUTE: begin
                if (mode_up) mode_next = MODE_SECOND;
                if (adj) e_min = (min_reg >= 6'd59) ? 6'd0 : min_reg + 6'd1;
            end
            MODE_SECOND: begin
                if (mode_up) mode_next = MODE_ALARM_ON;
                if (adj) e_sec = (sec_reg >= 6'd59) ? 6'd0 : sec_reg + 6'd1;
            end
            MODE_ALARM_ON: begin
                if (adj) aon_next = !aon_reg;
                if (mode_long) mode_next = MODE_ALARM_HOUR;
                else if (mode_up) mode_next = MODE_DAY;
            end
            MODE_ALARM_HOUR: begin
                page_next = 1'b1;
                if (adj) ahour_next = (ahour_reg >= 5'd23) ? 5'd0 : ahour_reg + 5'd1;
                if (mode_long) mode_next = MODE_DAY;
                else if (mode_up) mode_next = MODE_ALARM_MINUTE;
            end
            MODE_ALARM_MINUTE: begin
                if (mode_long) mode_next = MODE_DAY;
                else if (mode_up) mode_next = MODE_ALARM_SECOND;
                if (adj) amin_next = (amin_reg >= 6'd59) ? 6'd0 : amin_reg + 6'd1;
            end
            MODE_ALARM_SECOND: begin
                if (mode_up) mode_next = MODE_DAY;
                if (adj) asec_next = (asec_reg >= 6'd59) ? 6'd0 : asec_reg + 6'd1;
            end
            MODE_DAY: begin
                page_next = 1'b0;
                if (mode_up) mode_next = MODE_MONTH;
                if (adj) e_day = (day_reg >= 5'd31) ? 5'd1 : day_reg + 5'd1;
            end
            MODE_MONTH: begin
                if (mode_up) mode_next = MODE_YEAR;
                if (adj) e_month = (month_reg >= 4'd12) ? 4'd1 : month_reg + 4'd1;
            end
            MODE_YEAR: begin
                if (mode_up) mode_next = MODE_IDLE;
                if (adj) e_year = (year_reg >= 7'd99) ? 7'd0 : year_reg + 7'd1;
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    // Divider and one-second carry chain; the carry is paused while the alarm page shows
    assign div_dec  = div_reg - 8'd1;
    assign sec_tick = (div_dec == 8'd0) && !page_next;
    assign div_next = (div_dec == 8'd0) ? ccas_pkg::SCANS_PER_SECOND : div_dec;

    always_comb begin
        sec_next   = e_sec;
        min_next   = e_min;
        hour_next  = e_hour;
        day_next   = e_day;
        month_next = e_month;
        year_next  = e_year;
        if (sec_tick) begin
            if (e_sec < 6'd59) begin
                sec_next = e_sec + 6'd1;
            end else begin
                sec_next = 6'd0;
                if (e_min < 6'd59) begin
                    min_next = e_min + 6'd1;
                end else begin
                    min_next = 6'd0;
                    if (e_hour < 5'd23) begin
                        hour_next = e_hour + 5'd1;
                    end else begin
                        hour_next = 5'd0;
                        if (e_day < 5'd31) begin
                            day_next = e_day + 5'd1;
                        end else begin
                            day_next = 5'd1;
                            if (e_month >= 4'd12) begin
                                month_next = 4'd1;
                                year_next  = (e_year >= 7'd99) ? 7'd0 : e_year + 7'd1;
                            end else begin
                                month_next = e_month + 4'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    assign ring_next  = aon_next && (hour_next == ahour_next) && (min_next == amin_next)
                        && (sec_next <= ccas_pkg::RING_LAST_SECOND);
    assign blink_next = (mode_next != MODE_IDLE) && (div_next < ccas_pkg::BLINK_LIMIT);

    // State, handshake flags and registered outputs; payload has no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_start_reg <= ccas_pkg::REPEAT_START_RST;
            long_press_reg   <= ccas_pkg::LONG_PRESS_RST;
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            mode_reg         <= MODE_IDLE;
            div_reg          <= ccas_pkg::SCANS_PER_SECOND;
            sec_reg          <= 6'd0;
            min_reg          <= 6'd0;
            hour_reg         <= ccas_pkg::HOUR_RST;
            day_reg          <= 5'd1;
            month_reg        <= 4'd1;
            year_reg         <= 7'd0;
            wday_reg         <= 3'd0;
            ahour_reg        <= ccas_pkg::ALARM_HOUR_RST;
            amin_reg         <= 6'd0;
            asec_reg         <= 6'd0;
            aon_reg          <= 1'b0;
            page_reg         <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    ccas_pkg::CFG_REPEAT_START: repeat_start_reg <= cfg_data;
                    ccas_pkg::CFG_LONG_PRESS:   long_press_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_ready) in_valid_reg <= s_valid;
            if (m_ready || !m_valid_reg) m_valid_reg <= in_valid_reg;
            if (s_valid && s_ready) begin
                in_mode_reg   <= s_mode_hold;
                in_adjust_reg <= s_adjust_hold;
            end
            if (advance) begin
                mode_reg    <= mode_next;
                div_reg     <= div_next;
                sec_reg     <= sec_next;
                min_reg     <= min_next;
                hour_reg    <= hour_next;
                day_reg     <= day_next;
                month_reg   <= month_next;
                year_reg    <= year_next;
                wday_reg    <= wday_next;
                ahour_reg   <= ahour_next;
                amin_reg    <= amin_next;
                asec_reg    <= asec_next;
                aon_reg     <= aon_next;
                page_reg    <= page_next;
                m_hour_reg  <= page_next ? ahour_next : hour_next;
                m_min_reg   <= page_next ? amin_next : min_next;
                m_sec_reg   <= page_next ? asec_next : sec_next;
                m_day_reg   <= day_next;
                m_month_reg <= month_next;
                m_year_reg  <= year_next;
                m_wday_reg  <= wday_next;
                m_aon_reg   <= aon_next;
                m_ring_reg  <= ring_next;
                m_mode_reg  <= mode_next;
                m_blink_reg <= blink_next;
                m_page_reg  <= page_next;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_shown_hour      = m_hour_reg;
    assign m_shown_minute    = m_min_reg;
    assign m_shown_second    = m_sec_reg;
    assign m_day_of_month    = m_day_reg;
    assign m_month_number    = m_month_reg;
    assign m_year_in_century = m_year_reg;
    assign m_weekday         = m_wday_reg;
    assign m_alarm_enabled   = m_aon_reg;
    assign m_alarm_ringing   = m_ring_reg;
    assign m_edit_mode       = m_mode_reg;
    assign m_blink_phase     = m_blink_reg;
    assign m_alarm_page      = m_page_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // Divider never parks at zero or above its reload value
    a_div_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_reg != 8'd0) && (div_reg <= ccas_pkg::SCANS_PER_SECOND))
        else $error("tick divider out of range");

    // Month stays a calendar month
    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (month_reg >= 4'd1) && (month_reg <= 4'd12))
        else $error("month out of range");

    // A beat moved out of the input register always shows up as a result
    a_in_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("processed beat lost");

    // Ringing only with the alarm enabled
    a_ring_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ring_reg) |-> m_aon_reg)
        else $error("alarm rings while disabled");

endmodule
